### rtl/periodic_center_of_mass_coarse_grain_macros.svh
// assertion macros shared by the center of mass block
`ifndef PERIODIC_CENTER_OF_MASS_COARSE_GRAIN_MACROS_SVH
`define PERIODIC_CENTER_OF_MASS_COARSE_GRAIN_MACROS_SVH

// same-cycle implication
`define PCOM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pcom assertion failed");

// next-cycle implication
`define PCOM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pcom assertion failed");

`endif

### rtl/pcom_pkg.sv
// package with types, constants and the slot mass table of the center of mass block
package pcom_pkg;

  localparam int ATOMS     = 10;
  localparam int SLOT_W    = 4;
  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;
  localparam int POS_W     = 32;
  localparam int UNW_W     = POS_W + 1;
  localparam int MASS_W    = 20;
  localparam int PROD_W    = UNW_W + MASS_W + 1;
  localparam int WSUM_W    = 57;
  localparam int MAG_W     = WSUM_W - 1;
  localparam int RECIP_W   = 26;
  localparam int PA_W      = MAG_W - 32 + RECIP_W;
  localparam int PB_W      = 32 + RECIP_W;
  localparam int R_W       = PA_W + 1 - 16;
  localparam int C_W       = R_W + 1;
  localparam int FSUM_W    = 36;
  localparam int BOX_W     = 31;
  localparam int MPF_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DW     = 192;
  localparam int OUT_DW    = 216;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(ATOMS - 1);
  localparam logic [AXIS_W-1:0]  AXIS_LAST = AXIS_W'(AXES - 1);
  localparam logic [MASS_W-1:0]  MASS_O    = 20'd1048537;
  localparam logic [MASS_W-1:0]  MASS_C    = 20'd787133;
  localparam logic [MASS_W-1:0]  MASS_H    = 20'd66056;
  localparam logic [RECIP_W-1:0] RECIP_Q32 = 26'd48772051;
  localparam logic [BOX_W-1:0]   BOX_RST   = 31'd2074870;
  localparam logic [MPF_W-1:0]   MPF_RST   = 10'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_LENGTH,
    CFG_MOLECULES_PER_FRAME
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_MUL,
    ST_ABS,
    ST_MULH,
    ST_MULL,
    ST_ROUND,
    ST_SIGN,
    ST_WLO,
    ST_WHI,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UNWRAP,
    OP_MUL,
    OP_ABS,
    OP_MULH,
    OP_MULL,
    OP_ROUND,
    OP_SIGN,
    OP_WLO,
    OP_WHI,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic               load;
    dp_op_t             op;
    logic [AXIS_W-1:0]  axis;
    logic [SLOT_W-1:0]  slot;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

  function automatic logic [MASS_W-1:0] slot_mass(input logic [SLOT_W-1:0] s);
    logic [MASS_W-1:0] m;
    case (s) inside
      [4'd0:4'd2]: m = MASS_O;
      [4'd3:4'd5]: m = MASS_C;
      default:     m = MASS_H;
    endcase
    return m;
  endfunction

endpackage

### rtl/pcom_ctrl.sv
// controller state machine: atom slot and axis sequencing, input handshake
`include "periodic_center_of_mass_coarse_grain_macros.svh"

module pcom_ctrl
  import pcom_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t            state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    slot_nxt  = slot_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    cmd.slot  = slot_r;
    // last atom of a group waits until the previous result is taken
    in_tready = (state_r == ST_IDLE) && !((slot_r == SLOT_LAST) && stat.out_valid);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UNWRAP;
        end
      end
      ST_UNWRAP: begin
        cmd.op    = OP_UNWRAP;
        axis_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (axis_r == AXIS_LAST) begin
          axis_nxt = '0;
          if (slot_r == SLOT_LAST) begin
            slot_nxt  = '0;
            state_nxt = ST_ABS;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      ST_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = ST_MULH;
      end
      ST_MULH: begin
        cmd.op    = OP_MULH;
        state_nxt = ST_MULL;
      end
      ST_MULL: begin
        cmd.op    = OP_MULL;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        cmd.op    = OP_SIGN;
        state_nxt = ST_WLO;
      end
      ST_WLO: begin
        cmd.op    = OP_WLO;
        state_nxt = ST_WHI;
      end
      ST_WHI: begin
        cmd.op = OP_WHI;
        if (axis_r == AXIS_LAST) begin
          axis_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_ABS;
        end
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PCOM_ASSERT_IMP(a_last_atom_out_free, clk, rst_n, in_tvalid && in_tready && slot_r == SLOT_LAST, !stat.out_valid)
  `PCOM_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, state_r == ST_EMIT, stat.out_valid)
  `PCOM_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1, slot_r <= SLOT_LAST)
  `PCOM_ASSERT_NXT(a_finish_after_last, clk, rst_n, state_r == ST_MUL && axis_r == AXIS_LAST && slot_r == SLOT_LAST, state_r == ST_ABS && axis_r == '0)

endmodule

### rtl/pcom_dp.sv
// datapath: unwrap, mass-weighted accumulation, reciprocal scaling, wrap and output registers
module pcom_dp
  import pcom_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic [IN_DW-1:0]     in_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_wdata,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [OUT_DW-1:0]    out_tdata,
  output dp_stat_t             stat
);

  logic [BOX_W-1:0] box_r;
  logic [MPF_W-1:0] mpf_r;
  logic [MPF_W-1:0] mol_cnt_r;
  logic             out_valid_r;
  logic             prod_v_r;

  logic signed [POS_W-1:0]  pos_r  [AXES];
  logic signed [POS_W-1:0]  ref_r  [AXES];
  logic signed [UNW_W-1:0]  unw_r  [AXES];
  logic signed [WSUM_W-1:0] wsum_r [AXES];
  logic signed [FSUM_W-1:0] fsum_r [AXES];
  logic signed [PROD_W-1:0] prod_r;
  logic [AXIS_W-1:0]        prod_axis_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [PA_W-1:0]          pa_r;
  logic [PB_W-1:0]          pb_r;
  logic [R_W-1:0]           r_r;
  logic signed [C_W-1:0]    c_r;
  logic signed [POS_W-1:0]  out_com_r  [AXES];
  logic signed [FSUM_W-1:0] out_fsum_r [AXES];
  logic [MPF_W-1:0]         out_num_r;

  logic signed [UNW_W-1:0]  unw_nxt [AXES];
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [WSUM_W-1:0] wsum_sel;
  logic [WSUM_W-1:0]        wsum_neg;
  logic [PB_W-1:0]          pb_mul;
  logic [PA_W:0]            rsum;
  logic signed [C_W-1:0]    box_c;
  logic signed [C_W-1:0]    c_hi;
  logic signed [POS_W-1:0]  com_sat;
  logic [MPF_W-1:0]         num;

  // minimum-image unwrap against the reference atom, per axis
  always_comb begin
    logic signed [UNW_W-1:0] diff;
    logic signed [UNW_W:0]   diff2;
    logic signed [UNW_W:0]   boxd;
    logic signed [UNW_W-1:0] boxu;
    logic signed [UNW_W-1:0] posu;
    boxd = $signed({3'b000, box_r});
    boxu = $signed({2'b00, box_r});
    for (int k = 0; k < AXES; k++) begin
      posu  = {pos_r[k][POS_W-1], pos_r[k]};
      diff  = posu - $signed({ref_r[k][POS_W-1], ref_r[k]});
      diff2 = {diff, 1'b0};
      if (diff2 > boxd) begin
        unw_nxt[k] = posu - boxu;
      end else if (diff2 < -boxd) begin
        unw_nxt[k] = posu + boxu;
      end else begin
        unw_nxt[k] = posu;
      end
    end
  end

  assign prod_nxt = unw_r[cmd.axis] * $signed({1'b0, slot_mass(cmd.slot)});
  assign wsum_sel = wsum_r[cmd.axis];
  assign wsum_neg = -wsum_sel;
  assign pb_mul   = mag_r[31:0] * RECIP_Q32;
  assign rsum     = {1'b0, pa_r} + {{(PA_W + 1 - (PB_W - 32)){1'b0}}, pb_r[PB_W-1:32]};
  assign box_c    = $signed({{(C_W - BOX_W){1'b0}}, box_r});
  assign c_hi     = (c_r > box_c) ? (c_r - box_c) : c_r;
  assign num      = mol_cnt_r + 1'b1;

  always_comb begin
    if (c_hi > $signed({{(C_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}})) begin
      com_sat = {1'b0, {(POS_W - 1){1'b1}}};
    end else if (c_hi < $signed({{(C_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}})) begin
      com_sat = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      com_sat = c_hi[POS_W-1:0];
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r       <= BOX_RST;
      mpf_r       <= MPF_RST;
      mol_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BOX_LENGTH:          box_r <= cfg_wdata;
          CFG_MOLECULES_PER_FRAME: mpf_r <= cfg_wdata[MPF_W-1:0];
          default: ;
        endcase
      end
      prod_v_r <= (cmd.op == OP_MUL);
      if (cmd.op == OP_EMIT) begin
        mol_cnt_r   <= (num >= mpf_r) ? '0 : num;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      if (cmd.load) begin
        pos_r[k] <= in_tdata[k*POS_W +: POS_W];
        if (cmd.slot == '0) begin
          ref_r[k]  <= in_tdata[k*POS_W +: POS_W];
          fsum_r[k] <= {{(FSUM_W - POS_W){in_tdata[(AXES+k)*POS_W + POS_W - 1]}},
                        in_tdata[(AXES+k)*POS_W +: POS_W]};
        end else begin
          fsum_r[k] <= fsum_r[k] +
                       $signed({{(FSUM_W - POS_W){in_tdata[(AXES+k)*POS_W + POS_W - 1]}},
                                in_tdata[(AXES+k)*POS_W +: POS_W]});
        end
      end
      if (cmd.load && cmd.slot == '0) begin
        wsum_r[k] <= '0;
      end else if (prod_v_r && prod_axis_r == AXIS_W'(k)) begin
        wsum_r[k] <= wsum_r[k] + {{(WSUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
      end
      if (cmd.op == OP_UNWRAP) begin
        unw_r[k] <= unw_nxt[k];
      end
      if (cmd.op == OP_EMIT) begin
        out_fsum_r[k] <= fsum_r[k];
      end
    end
    if (cmd.op == OP_MUL) begin
      prod_r      <= prod_nxt;
      prod_axis_r <= cmd.axis;
    end
    case (cmd.op)
      OP_ABS: begin
        neg_r <= wsum_sel[WSUM_W-1];
        mag_r <= wsum_sel[WSUM_W-1] ? wsum_neg[MAG_W-1:0] : wsum_sel[MAG_W-1:0];
      end
      OP_MULH:  pa_r <= mag_r[MAG_W-1:32] * RECIP_Q32;
      OP_MULL:  pb_r <= pb_mul + (PB_W'(1) << 47);
      OP_ROUND: r_r  <= rsum[PA_W:16];
      OP_SIGN:  c_r  <= neg_r ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});
      OP_WLO: begin
        if (c_r < 0) begin
          c_r <= c_r + box_c;
        end
      end
      OP_WHI:   out_com_r[cmd.axis] <= com_sat;
      OP_EMIT:  out_num_r <= num;
      default: ;
    endcase
  end

  assign out_tvalid    = out_valid_r;
  assign stat.out_valid = out_valid_r;
  assign out_tdata = {2'b00, out_fsum_r[2], out_fsum_r[1], out_fsum_r[0],
                      out_com_r[2], out_com_r[1], out_com_r[0], out_num_r};

endmodule

### rtl/periodic_center_of_mass_coarse_grain.sv
// top level of the periodic center of mass coarse-graining block
// each atom request goes through accept, unwrap, then one shared multiply per axis
// then per axis for the tenth atom: abs, reciprocal multiply, round, sign, wrap; then emit
// the result is registered at emit; no further atom is accepted until the previous one has finished
// the tenth atom of a group is held off while the previous result is not yet taken
// synchronous active-low reset: slot, molecule count and output valid cleared, registers to defaults
module periodic_center_of_mass_coarse_grain
  import pcom_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DW-1:0]     in_tdata,   // pos_x, pos_y, pos_z, force_x, force_y, force_z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DW-1:0]    out_tdata,  // molecule_number, com_x, com_y, com_z,
                                           // total_force_x, total_force_y, total_force_z, pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcom_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule

### tb/sv/pcom_molecule_checker.sv
// checker for the center of mass block: predicts each molecule result and compares it
module pcom_molecule_checker
  import pcom_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DW-1:0]     in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_DW-1:0]    out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  localparam longint OXYGEN_Q16     = 1048537;
  localparam longint CARBON_Q16     = 787133;
  localparam longint HYDROGEN_Q16   = 66056;
  localparam longint INV_TOTAL_MASS = 48772051;
  localparam longint CENTER_MAX     = 64'sh7FFFFFFF;
  localparam longint CENTER_MIN     = -64'sh80000000;

  typedef struct packed {
    logic [1:0]  pad;
    logic [35:0] fz;
    logic [35:0] fy;
    logic [35:0] fx;
    logic [31:0] cz;
    logic [31:0] cy;
    logic [31:0] cx;
    logic [9:0]  number;
  } molecule_t;

  logic [BOX_W-1:0] box;
  logic [MPF_W-1:0] per_frame;
  logic [3:0]       slot_idx;
  logic [MPF_W-1:0] frame_count;
  longint           anchor [3];
  longint           weighted [3];
  longint           force_total [3];
  molecule_t        expected_molecules [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic longint atom_mass(input logic [3:0] s);
    if (s < 3) return OXYGEN_Q16;
    if (s < 6) return CARBON_Q16;
    return HYDROGEN_Q16;
  endfunction

  // round half away from zero on the magnitude, then wrap once into the box and saturate to the signed 32-bit range
  function automatic logic [31:0] wrapped_center(input longint sum, input longint b);
    logic [127:0] scaled;
    longint       c;
    scaled = (sum < 0) ? 128'(-sum) : 128'(sum);
    scaled = (scaled * 128'(INV_TOTAL_MASS) + (128'(1) << 47)) >> 48;
    c = longint'({1'b0, scaled[62:0]});
    if (sum < 0) c = -c;
    if (c < 0) c += b;
    if (c > b) c -= b;
    if (c > CENTER_MAX) c = CENTER_MAX;
    if (c < CENTER_MIN) c = CENTER_MIN;
    return c[31:0];
  endfunction

  function automatic void absorb_atom(input logic [IN_DW-1:0] atom);
    longint      p;
    longint      d;
    longint      b;
    int unsigned number;
    molecule_t   m;
    b = longint'({33'd0, box});
    for (int k = 0; k < 3; k++) begin
      p = longint'($signed(atom[32*k +: 32]));
      if (slot_idx == 0) begin
        anchor[k]      = p;
        weighted[k]    = 0;
        force_total[k] = 0;
      end
      d = 2 * (p - anchor[k]);
      if (d > b) p -= b;
      else if (d < -b) p += b;
      weighted[k]    += p * atom_mass(slot_idx);
      force_total[k] += longint'($signed(atom[96 + 32*k +: 32]));
    end
    if (slot_idx != 4'(ATOMS - 1)) begin
      slot_idx++;
      return;
    end
    slot_idx = 0;
    number = frame_count + 1;
    frame_count = (number >= per_frame) ? '0 : MPF_W'(number);
    m.pad    = '0;
    m.number = MPF_W'(number);
    m.cx     = wrapped_center(weighted[0], b);
    m.cy     = wrapped_center(weighted[1], b);
    m.cz     = wrapped_center(weighted[2], b);
    m.fx     = force_total[0][35:0];
    m.fy     = force_total[1][35:0];
    m.fz     = force_total[2][35:0];
    expected_molecules.push_back(m);
  endfunction

  function automatic void check_field(input string field, input logic [9:0] mol,
                                      input logic [35:0] want, input logic [35:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch molecule %0d %s: expected %h got %h", mol, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    molecule_t got;
    molecule_t want;
    if (!rst_n) begin
      box         = BOX_RST;
      per_frame   = MPF_RST;
      slot_idx    = '0;
      frame_count = '0;
      for (int k = 0; k < 3; k++) begin
        anchor[k]      = 0;
        weighted[k]    = 0;
        force_total[k] = 0;
      end
      expected_molecules.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_molecules.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing expected: %h", out_tdata);
        end else begin
          want = expected_molecules.pop_front();
          check_field("molecule_number", want.number, 36'(want.number), 36'(got.number));
          check_field("com_x", want.number, 36'(want.cx), 36'(got.cx));
          check_field("com_y", want.number, 36'(want.cy), 36'(got.cy));
          check_field("com_z", want.number, 36'(want.cz), 36'(got.cz));
          check_field("total_force_x", want.number, want.fx, got.fx);
          check_field("total_force_y", want.number, want.fy, got.fy);
          check_field("total_force_z", want.number, want.fz, got.fz);
        end
      end
      if (in_tvalid && in_tready) absorb_atom(in_tdata);
      if (cfg_we) begin
        if (cfg_index == CFG_BOX_LENGTH) box = cfg_wdata;
        else per_frame = cfg_wdata[MPF_W-1:0];
      end
    end
    outstanding = expected_molecules.size();
  end

endmodule

### tb/sv/testbench.sv
// top of the center of mass testbench: clock, reset, atom requests, result stalls and verdict
module testbench
  import pcom_pkg::*;
();

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          QUIET       = 64;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [31:0] P_MAX       = 32'h7FFFFFFF;
  localparam logic [31:0] P_MIN       = 32'h80000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DW-1:0]     in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BOX_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   outstanding;

  int          cycles        = 0;
  int          sent          = 0;
  int          send_calm     = 0;
  int          hold_requests = 0;
  longint      box_now       = longint'(BOX_RST);
  logic [31:0] anchor [3];
  bit          noisy;

  periodic_center_of_mass_coarse_grain i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pcom_molecule_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // calm stretches with no idling between random gaps
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  // result side
  initial begin
    int gap;
    int calm;
    int holds_done;
    calm       = 0;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      if (hold_requests != holds_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      gap = draw_gap(calm);
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_atom(input logic [31:0] px, py, pz, fx, fy, fz);
    int gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {fz, fy, fx, pz, py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // atoms of a group sit near its first atom, some one box away, on the half-box edge, random or at the extremes
  task automatic send_random_atom();
    logic [31:0] pos [3];
    logic [31:0] frc [3];
    longint      delta;
    longint      sgn;
    int          kind;
    if (sent % ATOMS == 0) begin
      noisy = ($urandom_range(0, 6) == 0);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: anchor[k] = $urandom;
          1: anchor[k] = $urandom_range(0, 32'(box_now));
          2: anchor[k] = $urandom_range(0, 2000);
          default: anchor[k] = 32'(box_now - longint'($urandom_range(0, 2000)));
        endcase
      end
    end
    for (int k = 0; k < 3; k++) begin
      kind = $urandom_range(0, 9);
      sgn  = $urandom_range(0, 1) ? 1 : -1;
      case (kind)
        5: delta = box_now - longint'($urandom_range(0, 32'(box_now / 8)));
        6: delta = longint'($urandom_range(0, 32'(box_now / 8))) - box_now;
        7: delta = sgn * (box_now / 2 + longint'($urandom_range(0, 2)) - 1);
        default: delta = sgn * longint'($urandom_range(0, 32'(box_now / 4)));
      endcase
      pos[k] = 32'(longint'($signed(anchor[k])) + delta);
      if (kind == 8 || noisy) pos[k] = $urandom;
      if (kind == 9) pos[k] = $urandom_range(0, 1) ? P_MAX : P_MIN;
      if (sent % ATOMS == 0 && !noisy) pos[k] = anchor[k];
      case ($urandom_range(0, 15))
        0: frc[k] = P_MAX;
        1: frc[k] = P_MIN;
        default: frc[k] = $urandom;
      endcase
    end
    send_atom(pos[0], pos[1], pos[2], frc[0], frc[1], frc[2]);
  endtask

  task automatic drain(input int quiet);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (quiet) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [BOX_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [BOX_W-1:0] nb;
    logic [MPF_W-1:0] nm;
    int               items;
    longint           hb;
    longint           off;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BOX_LENGTH;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // extreme coordinates and forces, center above the box
    for (int i = 0; i < ATOMS; i++)
      send_atom(i == 5 ? P_MIN : P_MAX, P_MAX, i == 5 ? P_MIN : P_MAX, P_MAX, P_MAX, P_MAX);
    // exactly half a box stays, one past it moves, center below zero
    hb = longint'(BOX_RST) / 2;
    for (int i = 0; i < ATOMS; i++) begin
      off = (i == 0) ? 0 : ((i % 2) ? 1 : -1);
      send_atom(32'(off * hb), 32'(off * (hb + 1)), 32'(-1000 * i), P_MIN, P_MIN, P_MIN);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nb = 31'h7FFFFFFF; nm = 10'd1; end
        1: begin nb = '0; nm = '0; end
        2: begin nb = BOX_W'($urandom); nm = 10'd1023; end
        3: begin nb = BOX_W'($urandom_range(1, 65535)); nm = 10'd2; end
        4: begin nb = BOX_RST; nm = 10'd7; end
        5: begin nb = BOX_W'($urandom); nm = MPF_W'($urandom_range(1, 30)); end
        6: begin
          nb = BOX_W'($urandom_range(0, 1000));
          nm = MPF_W'($urandom_range(0, 1023));
        end
        default: begin nb = BOX_W'($urandom); nm = 10'd5; end
      endcase
      drain(QUIET);
      write_reg(CFG_BOX_LENGTH, nb);
      box_now = longint'(nb);
      write_reg(CFG_MOLECULES_PER_FRAME, BOX_W'(nm));
      if (ph == 2) hold_requests++;
      items = 200 + $urandom_range(0, 15);
      for (int i = 0; i < items; i++) begin
        if (ph == 2 && i == 120) drain(0);
        send_random_atom();
      end
    end
    drain(QUIET);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/pcom_pkg.sv
rtl/pcom_ctrl.sv
rtl/pcom_dp.sv
rtl/periodic_center_of_mass_coarse_grain.sv
tb/sv/pcom_molecule_checker.sv
tb/sv/testbench.sv
